>>> hw/rtl/scle_pkg.sv
`timescale 1ns / 1ps

package scle_pkg;

  localparam logic [7:0] SC_LEFT    = 8'h4B;
  localparam logic [7:0] SC_RIGHT   = 8'h4D;
  localparam logic [7:0] SC_ENTER   = 8'h1C;
  localparam logic [7:0] SC_BACK    = 8'h0E;
  localparam int         REL_BIT    = 7;
  localparam logic [10:0] OFFSET_RESET = 11'd80;

  localparam logic [2:0] LINE_CMD_EMPTY   = 3'd0;
  localparam logic [2:0] LINE_CMD_HELP    = 3'd1;
  localparam logic [2:0] LINE_CMD_CLEAR   = 3'd2;
  localparam logic [2:0] LINE_CMD_VERSION = 3'd3;
  localparam logic [2:0] LINE_CMD_ECHO    = 3'd4;
  localparam logic [2:0] LINE_CMD_UNKNOWN = 3'd5;

  typedef enum logic [2:0] {
    EV_ECHO  = 3'd0,
    EV_ERASE = 3'd1,
    EV_MOVE  = 3'd2,
    EV_LCHAR = 3'd3,
    EV_LEND  = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_LEFT,
    K_RIGHT,
    K_ENTER,
    K_BACK,
    K_CHAR
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_D_START,
    S_D_SHIFT,
    S_I_START,
    S_I_SHIFT,
    S_I_PUT,
    S_E_OUT,
    S_E_END,
    S_EMIT_MOVE,
    S_EMIT_ECHO,
    S_EMIT_ERASE
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_LEN,
    IDX_CUR_M1,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_IDX_P1,
    RD_IDX_P2,
    RD_IDX_M1,
    RD_IDX_M2
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT,
    WR_CHAR
  } wr_sel_t;

  typedef struct packed {
    logic    sc_load;
    logic    cur_inc;
    logic    cur_dec;
    logic    len_inc;
    logic    len_dec;
    logic    line_clr;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    out_load;
    ev_t     out_ev;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cur_zero;
    logic  cur_at_end;
    logic  len_zero;
    logic  len_full;
    logic  idx_lt_len;
    logic  idx_p1_lt_len;
    logic  idx_gt_cur;
    logic  idx_m1_gt_cur;
    logic  out_free;
  } dp_stat_t;

  function automatic logic [6:0] key_map(input logic [6:0] code);
    logic [6:0] ch;
    unique case (code)
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;
      7'h1E: ch = 7'h61;
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6A;
      7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;
      7'h2C: ch = 7'h7A;
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6E;
      7'h32: ch = 7'h6D;
      7'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] cmd_of(input logic [6:0] ch);
    logic [2:0] cmd;
    unique case (ch)
      7'h68:   cmd = LINE_CMD_HELP;
      7'h63:   cmd = LINE_CMD_CLEAR;
      7'h76:   cmd = LINE_CMD_VERSION;
      7'h65:   cmd = LINE_CMD_ECHO;
      default: cmd = LINE_CMD_UNKNOWN;
    endcase
    return cmd;
  endfunction

endpackage

>>> hw/rtl/scle_ctrl.sv
`timescale 1ns / 1ps

module scle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  scle_pkg::dp_stat_t stat,
  output scle_pkg::dp_cmd_t  cmd
);
  import scle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.idx_op   = IDX_HOLD;
    cmd.rd_sel   = RD_ZERO;
    cmd.wr_sel   = WR_SHIFT;
    cmd.out_ev   = EV_ECHO;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.sc_load = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.kind)
          K_LEFT: begin
            if (!stat.cur_zero) begin
              cmd.cur_dec = 1'b1;
              state_next  = S_EMIT_MOVE;
            end
          end
          K_RIGHT: begin
            if (!stat.cur_at_end) begin
              cmd.cur_inc = 1'b1;
              state_next  = S_EMIT_MOVE;
            end
          end
          K_ENTER: begin
            cmd.idx_op = IDX_ZERO;
            if (stat.len_zero) begin
              state_next = S_E_END;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ZERO;
              state_next = S_E_OUT;
            end
          end
          K_BACK: begin
            if (!stat.cur_zero) begin
              cmd.cur_dec = 1'b1;
              cmd.len_dec = 1'b1;
              cmd.idx_op  = IDX_CUR_M1;
              state_next  = S_D_START;
            end
          end
          K_CHAR: begin
            if (!stat.len_full) begin
              cmd.idx_op = IDX_LEN;
              state_next = S_I_START;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_D_START: begin
        if (stat.idx_lt_len) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
          state_next = S_D_SHIFT;
        end else begin
          state_next = S_EMIT_ERASE;
        end
      end
      S_D_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        if (stat.idx_p1_lt_len) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P2;
          cmd.idx_op = IDX_INC;
        end else begin
          state_next = S_EMIT_ERASE;
        end
      end
      S_I_START: begin
        if (stat.idx_gt_cur) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_next = S_I_SHIFT;
        end else begin
          state_next = S_I_PUT;
        end
      end
      S_I_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        if (stat.idx_m1_gt_cur) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M2;
          cmd.idx_op = IDX_DEC;
        end else begin
          state_next = S_I_PUT;
        end
      end
      S_I_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_CHAR;
        cmd.cur_inc = 1'b1;
        cmd.len_inc = 1'b1;
        state_next  = S_EMIT_ECHO;
      end
      S_E_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_LCHAR;
          if (stat.idx_p1_lt_len) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX_P1;
            cmd.idx_op = IDX_INC;
          end else begin
            state_next = S_E_END;
          end
        end
      end
      S_E_END: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_LEND;
          cmd.line_clr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMIT_MOVE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_MOVE;
          state_next   = S_IDLE;
        end
      end
      S_EMIT_ECHO: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_ECHO;
          state_next   = S_IDLE;
        end
      end
      S_EMIT_ERASE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_ERASE;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/scle_datapath.sv
`timescale 1ns / 1ps

module scle_datapath #(
  parameter int LINE_CAP = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_data,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  scle_pkg::dp_cmd_t  cmd,
  output scle_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_data,
  output logic               out_last
);
  import scle_pkg::*;

  localparam int LW = $clog2(LINE_CAP + 1);
  localparam int AW = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  logic [7:0]    sc;
  logic [LW-1:0] cursor;
  logic [LW-1:0] len;
  logic [LW-1:0] idx;
  logic [10:0]   offset;
  logic [6:0]    first_char;
  logic [6:0]    rdata;
  logic [6:0]    mem [LINE_CAP];

  logic [LW-1:0] raddr;
  logic [LW-1:0] waddr;
  logic [6:0]    wdata;
  logic [6:0]    ch;
  logic [LW:0]   idx_p1;
  logic [LW:0]   cur_p1;

  ev_t        out_ev;
  logic [6:0] out_char;
  logic [11:0] out_pos;
  logic [2:0] out_cmd;

  assign ch     = key_map(sc[6:0]);
  assign idx_p1 = {1'b0, idx} + (LW+1)'(1);
  assign cur_p1 = {1'b0, cursor} + (LW+1)'(1);

  always_comb begin
    stat.kind = K_NONE;
    if (sc == SC_LEFT) begin
      stat.kind = K_LEFT;
    end else if (sc == SC_RIGHT) begin
      stat.kind = K_RIGHT;
    end else if (sc[REL_BIT]) begin
      stat.kind = K_NONE;
    end else if (sc == SC_ENTER) begin
      stat.kind = K_ENTER;
    end else if (sc == SC_BACK) begin
      stat.kind = K_BACK;
    end else if (ch != 7'd0) begin
      stat.kind = K_CHAR;
    end
    stat.cur_zero      = (cursor == '0);
    stat.cur_at_end    = (cursor == len);
    stat.len_zero      = (len == '0);
    stat.len_full      = (len == LW'(LINE_CAP));
    stat.idx_lt_len    = (idx < len);
    stat.idx_p1_lt_len = (idx_p1 < {1'b0, len});
    stat.idx_gt_cur    = (idx > cursor);
    stat.idx_m1_gt_cur = ({1'b0, idx} > cur_p1);
    stat.out_free      = !out_valid || out_ready;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:   raddr = '0;
      RD_IDX_P1: raddr = idx + LW'(1);
      RD_IDX_P2: raddr = idx + LW'(2);
      RD_IDX_M1: raddr = idx - LW'(1);
      RD_IDX_M2: raddr = idx - LW'(2);
      default:   raddr = '0;
    endcase
    unique case (cmd.wr_sel)
      WR_SHIFT: begin
        waddr = idx;
        wdata = rdata;
      end
      WR_CHAR: begin
        waddr = cursor;
        wdata = ch;
      end
      default: begin
        waddr = idx;
        wdata = rdata;
      end
    endcase
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      len    <= '0;
      offset <= OFFSET_RESET;
    end else begin
      if (cfg_we) begin
        offset <= cfg_wdata;
      end
      if (cmd.line_clr) begin
        cursor <= '0;
        len    <= '0;
      end else begin
        if (cmd.cur_inc) begin
          cursor <= cursor + LW'(1);
        end else if (cmd.cur_dec) begin
          cursor <= cursor - LW'(1);
        end
        if (cmd.len_inc) begin
          len <= len + LW'(1);
        end else if (cmd.len_dec) begin
          len <= len - LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_load) begin
      sc <= in_data;
    end
    unique case (cmd.idx_op)
      IDX_HOLD:   idx <= idx;
      IDX_ZERO:   idx <= '0;
      IDX_LEN:    idx <= len;
      IDX_CUR_M1: idx <= cursor - LW'(1);
      IDX_INC:    idx <= idx + LW'(1);
      IDX_DEC:    idx <= idx - LW'(1);
      default:    idx <= idx;
    endcase
    if (cmd.out_load && cmd.out_ev == EV_LCHAR && idx == '0) begin
      first_char <= rdata;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ev   <= cmd.out_ev;
      out_last <= (cmd.out_ev != EV_LCHAR);
      out_char <= (cmd.out_ev == EV_ECHO) ? ch :
                  ((cmd.out_ev == EV_LCHAR) ? rdata : 7'd0);
      out_pos  <= (cmd.out_ev == EV_MOVE) ? 12'(cursor) + 12'(offset) : 12'd0;
      out_cmd  <= (cmd.out_ev == EV_LEND && !stat.len_zero) ? cmd_of(first_char) :
                  LINE_CMD_EMPTY;
    end
  end

  assign out_data = {7'd0, out_cmd, out_pos, out_char, out_ev};

endmodule

>>> hw/rtl/scancode_line_editor_core.sv
`timescale 1ns / 1ps

// Line editor fed with keyboard scancode set 1 bytes, one byte per input word.
// Bytes are taken only while the editor is idle; the output word register lets a
// new byte be taken while the last result still waits. A typed character or a
// backspace in the middle of the line shifts the tail through the line store, which
// has one read and one write port, one entry a cycle; enter sends one line character
// a cycle from that store while the sink accepts words, then the end word. A sink
// that holds off a waiting word stalls the editor. The line store needs no clearing
// after reset.
module scancode_line_editor_core #(
  parameter int LINE_CAP = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // scancode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // event_res, char_code, position, command, zero fill
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata  // cursor_offset
);
  import scle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  scle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scle_datapath #(
    .LINE_CAP (LINE_CAP)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
